>>> src/tmtw_pkg.sv
package tmtw_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;
  localparam int unsigned CFG_DATA_W = 4;

  localparam logic [7:0]  CH_NEWLINE = 8'h0A;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam int unsigned TAB_STEP   = 4;
  localparam logic [15:0] RESET_CELL = 16'h0F20;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [15:0] cell_data;
    logic        scrolled;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic copy;
    logic fill;
    logic cnt_inc;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       need_scroll;
    logic       at_lim;
    logic       at_last;
  } sts_t;

  function automatic logic [15:0] make_cell(input logic [3:0] fg, input logic [3:0] bg,
                                            input logic [7:0] ch);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

>>> src/tmtw_dp.sv
module tmtw_dp #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tmtw_pkg::in_t                      in_data,
  input  logic                               cfg_we,
  input  logic [tmtw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmtw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  tmtw_pkg::cmd_t                     cmd,
  output tmtw_pkg::sts_t                     sts,
  output tmtw_pkg::out_t                     out_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int LIM   = (ROWS - 1) * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int IW    = (AW > 11) ? AW : 11;

  logic [15:0]   cells_mem [CELLS];
  logic [15:0]   rdata_r;

  logic [3:0]    fg_r, bg_r;
  logic [1:0]    req_r;
  logic [7:0]    ch_r;
  logic          inrange_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          scr_r, scr_nxt;
  logic [AW-1:0] cnt_r;
  logic [15:0]   blank_r;
  tmtw_pkg::out_t out_r;

  logic [CW:0]   col_a;
  logic [RW:0]   row_a, row_b;
  logic [CW-1:0] col_b;
  logic          wrap, need_scroll;
  logic [RW-1:0] row_fin;
  logic [IW-1:0] idx_w;
  logic          in_range;
  logic [AW-1:0] pos, offset;
  logic [IW-1:0] offset_w;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;
  logic          glyph;

  // cursor advance for a write request
  always_comb begin
    row_a = {1'b0, row_r};
    col_a = {1'b0, col_r};
    if (ch_r == tmtw_pkg::CH_NEWLINE) begin
      row_a = row_a + (RW+1)'(1);
      col_a = '0;
    end else if (ch_r == tmtw_pkg::CH_TAB) begin
      col_a = col_a + (CW+1)'(tmtw_pkg::TAB_STEP);
    end else begin
      col_a = col_a + (CW+1)'(1);
    end
    wrap        = col_a >= (CW+1)'(COLS);
    row_b       = wrap ? row_a + (RW+1)'(1) : row_a;
    col_b       = wrap ? '0 : col_a[CW-1:0];
    need_scroll = row_b >= (RW+1)'(ROWS);
    row_fin     = need_scroll ? RW'(ROWS - 1) : row_b[RW-1:0];
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    scr_nxt = scr_r;
    if (cmd.accept) begin
      scr_nxt = 1'b0;
    end
    if (cmd.exec && req_r == tmtw_pkg::REQ_WRITE) begin
      row_nxt = row_fin;
      col_nxt = col_b;
      scr_nxt = need_scroll;
    end else if (cmd.exec && req_r == tmtw_pkg::REQ_CLEAR) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  assign idx_w    = IW'(in_data.cell_index);
  assign in_range = idx_w < IW'(CELLS);
  assign pos      = AW'(row_r) * AW'(COLS) + AW'(col_r);
  assign offset   = AW'(row_nxt) * AW'(COLS) + AW'(col_nxt);
  assign offset_w = IW'(offset);
  assign glyph    = cmd.exec && req_r == tmtw_pkg::REQ_WRITE &&
                    ch_r != tmtw_pkg::CH_NEWLINE && ch_r != tmtw_pkg::CH_TAB;

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_r;
    wdata = blank_r;
    re    = 1'b0;
    raddr = AW'(idx_w);
    if (cmd.accept) begin
      re = in_range;
    end
    if (glyph) begin
      we    = 1'b1;
      waddr = pos;
      wdata = tmtw_pkg::make_cell(fg_r, bg_r, ch_r);
    end
    if (cmd.copy) begin
      // read one row down, write the cell fetched last cycle
      re    = !sts.at_lim;
      raddr = cnt_r + AW'(COLS);
      we    = cnt_r != '0;
      waddr = cnt_r - AW'(1);
      wdata = rdata_r;
    end
    if (cmd.fill) begin
      we    = 1'b1;
      waddr = cnt_r;
      wdata = blank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= cells_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r    <= 4'hF;
      bg_r    <= 4'h0;
      row_r   <= '0;
      col_r   <= '0;
      scr_r   <= 1'b0;
      cnt_r   <= '0;
      blank_r <= tmtw_pkg::RESET_CELL;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tmtw_pkg::CFG_FG: fg_r <= cfg_data;
          tmtw_pkg::CFG_BG: bg_r <= cfg_data;
        endcase
      end
      row_r <= row_nxt;
      col_r <= col_nxt;
      scr_r <= scr_nxt;
      if (cmd.accept) begin
        cnt_r   <= '0;
        blank_r <= tmtw_pkg::make_cell(fg_r, bg_r, tmtw_pkg::CH_SPACE);
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= in_data.req_type;
      ch_r      <= in_data.char_code;
      inrange_r <= in_range;
    end
    if (cmd.load_out) begin
      out_r.cursor_offset <= offset_w[10:0];
      out_r.cell_data     <= (req_r == tmtw_pkg::REQ_READ && inrange_r) ? rdata_r : 16'h0;
      out_r.scrolled      <= scr_nxt;
    end
  end

  assign sts.req         = req_r;
  assign sts.need_scroll = need_scroll;
  assign sts.at_lim      = cnt_r == AW'(LIM);
  assign sts.at_last     = cnt_r == AW'(CELLS - 1);
  assign out_data        = out_r;

endmodule

>>> src/tmtw_ctrl.sv
module tmtw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tmtw_pkg::sts_t sts,
  output tmtw_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_FILL,
    S_DONE
  } state_t;

  state_t state_r;
  logic   init_r;
  logic   out_valid_r;
  logic   free;
  logic   simple;

  assign free   = !out_valid_r || !out_stall;
  assign simple = !(sts.req == tmtw_pkg::REQ_CLEAR) &&
                  !(sts.req == tmtw_pkg::REQ_WRITE && sts.need_scroll);

  always_comb begin
    cmd          = '0;
    cmd.accept   = state_r == S_IDLE && in_valid;
    cmd.exec     = state_r == S_EXEC;
    cmd.copy     = state_r == S_COPY;
    cmd.fill     = state_r == S_FILL;
    cmd.cnt_inc  = (state_r == S_COPY && !sts.at_lim) || state_r == S_FILL;
    cmd.load_out = free && ((state_r == S_EXEC && simple) || state_r == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;  // blank the store after reset
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          priority if (sts.req == tmtw_pkg::REQ_CLEAR) begin
            state_r <= S_FILL;
          end else if (sts.req == tmtw_pkg::REQ_WRITE && sts.need_scroll) begin
            state_r <= S_COPY;
          end else if (free) begin
            state_r <= S_IDLE;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_COPY: begin
          if (sts.at_lim) begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          if (sts.at_last) begin
            if (init_r) begin
              init_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> src/text_mode_terminal_writer.sv
// text-mode console: a ROWS x COLS store of attribute/character cells and a cursor
// input channel in_valid/in_stall/in_data takes one request: write a character,
// clear the screen or read one cell; each request gives exactly one result on
// out_valid/out_stall/out_data with the cursor offset after the request
// config port: cfg_we with cfg_index 0 sets the foreground nibble, 1 the background
// write glyph, newline, tab, read or unused code: the request is taken with its
// registered read; exec writes any glyph, and the result loads once the output is free
// a write that runs off the bottom scrolls, one cell moved or blanked per cycle
// through one read and one write port of the store
// clear: one cell blanked per cycle
// one request is worked on at a time; the next is taken as soon as the previous
// result sits in the output register, even while the receiver stalls it
// a result held by out_stall stays unchanged until taken
// after reset the block blanks the store to white-on-black spaces with in_stall
// high; configuration writes are taken during that pass
module text_mode_terminal_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tmtw_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tmtw_pkg::out_t                     out_data,
  input  logic                               cfg_we,
  input  logic [tmtw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmtw_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tmtw_pkg::cmd_t cmd;
  tmtw_pkg::sts_t sts;

  tmtw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmtw_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

>>> tb/text_mode_terminal_writer_tb.sv
module text_mode_terminal_writer_tb;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int NCELLS = ROWS * COLS;
  localparam int HALF_PERIOD = 6;
  localparam int SEGMENTS = 6;
  localparam int SEG_REQS = 155;
  // no request code of its own in the package
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tmtw_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tmtw_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [tmtw_pkg::CFG_IDX_W-1:0] cfg_index = tmtw_pkg::CFG_FG;
  logic [tmtw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  tmtw_pkg::in_t req_fifo[$];
  tmtw_pkg::out_t expected_replies[$];
  logic in_fire = 1'b0;
  int src_gap_pct = 38;
  int snk_stall_pct = 65;
  int failures = 0;

  // shadow copy of the console
  logic [15:0] shadow_screen [0:NCELLS-1];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [3:0] fg_nib;
  logic [3:0] bg_nib;

  text_mode_terminal_writer #(.ROWS(ROWS), .COLS(COLS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  task automatic blank_screen();
    for (int i = 0; i < NCELLS; i++) shadow_screen[i] = {bg_nib, fg_nib, tmtw_pkg::CH_SPACE};
  endtask

  task automatic console_apply(input tmtw_pkg::in_t r, output tmtw_pkg::out_t res);
    int unsigned pos;
    res = '0;
    case (r.req_type)
      tmtw_pkg::REQ_WRITE: begin
        if (r.char_code == tmtw_pkg::CH_NEWLINE) begin
          cur_row++;
          cur_col = 0;
        end else if (r.char_code == tmtw_pkg::CH_TAB) begin
          cur_col += tmtw_pkg::TAB_STEP;
        end else begin
          pos = cur_row * COLS + cur_col;
          if (pos < NCELLS) shadow_screen[pos] = {bg_nib, fg_nib, r.char_code};
          cur_col++;
        end
        // tab overflow past the edge is dropped
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLS; i++)
            shadow_screen[i] = shadow_screen[i + COLS];
          for (int i = (ROWS - 1) * COLS; i < NCELLS; i++)
            shadow_screen[i] = {bg_nib, fg_nib, tmtw_pkg::CH_SPACE};
          cur_row = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      tmtw_pkg::REQ_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      tmtw_pkg::REQ_READ: begin
        if (r.cell_index < NCELLS) res.cell_data = shadow_screen[r.cell_index];
      end
      default: ;
    endcase
    res.cursor_offset = 11'(cur_row * COLS + cur_col);
  endtask

  function automatic tmtw_pkg::in_t make_req(input logic [1:0] kind, input logic [7:0] ch,
                                             input logic [10:0] idx);
    tmtw_pkg::in_t r;
    r.req_type = kind;
    r.char_code = ch;
    r.cell_index = idx;
    return r;
  endfunction

  function automatic tmtw_pkg::in_t random_req();
    tmtw_pkg::in_t r;
    int pick;
    int sel;
    r = tmtw_pkg::in_t'($urandom);
    pick = $urandom_range(999);
    if (pick < 740) begin
      r.req_type = tmtw_pkg::REQ_WRITE;
      sel = $urandom_range(99);
      if (sel < 12) r.char_code = tmtw_pkg::CH_NEWLINE;
      else if (sel < 20) r.char_code = tmtw_pkg::CH_TAB;
      else r.char_code = 8'($urandom_range(255));
    end else if (pick < 940) begin
      r.req_type = tmtw_pkg::REQ_READ;
      if ($urandom_range(99) < 90) r.cell_index = 11'($urandom_range(NCELLS - 1));
      else r.cell_index = 11'($urandom_range(2047, NCELLS));
    end else if (pick < 993) begin
      r.req_type = REQ_UNUSED;
    end else begin
      r.req_type = tmtw_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (req_fifo.size() != 0 || in_valid || expected_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_colours(input logic [3:0] fg, input logic [3:0] bg);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= tmtw_pkg::CFG_FG;
    cfg_data <= fg;
    @(negedge clk);
    cfg_index <= tmtw_pkg::CFG_BG;
    cfg_data <= bg;
    @(negedge clk);
    cfg_we <= 1'b0;
    fg_nib = fg;
    bg_nib = bg;
  endtask

  // request driver
  always @(negedge clk) begin
    if (in_valid && !in_fire) begin
      // stalled request holds
    end else if (rst_n && req_fifo.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
      in_valid <= 1'b1;
      in_data <= req_fifo.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) out_stall <= ($urandom_range(99) < snk_stall_pct);

  always @(posedge clk) begin
    tmtw_pkg::out_t want;
    tmtw_pkg::out_t pred;
    in_fire = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $display("%0t unexpected result: expected none, got %h", $time, out_data);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        if (out_data.cursor_offset !== want.cursor_offset) begin
          $display("%0t cursor_offset mismatch: expected %0d, got %0d", $time,
                   want.cursor_offset, out_data.cursor_offset);
          failures++;
        end
        if (out_data.cell_data !== want.cell_data) begin
          $display("%0t cell_data mismatch: expected %h, got %h", $time,
                   want.cell_data, out_data.cell_data);
          failures++;
        end
        if (out_data.scrolled !== want.scrolled) begin
          $display("%0t scrolled mismatch: expected %b, got %b", $time,
                   want.scrolled, out_data.scrolled);
          failures++;
        end
      end
    end
    if (in_fire) begin
      console_apply(in_data, pred);
      expected_replies.push_back(pred);
    end
  end

  initial begin
    logic [3:0] fg_set [SEGMENTS];
    logic [3:0] bg_set [SEGMENTS];
    fg_nib = 4'hF;
    bg_nib = 4'h0;
    cur_row = 0;
    cur_col = 0;
    blank_screen();
    fg_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'($urandom), 4'($urandom)};
    bg_set = '{4'h0, 4'hF, 4'hF, 4'h0, 4'($urandom), 4'($urandom)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset contents, out of range reads, glyph extremes, tab, newline, unused code, clear
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd0));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'hFF, 11'd1999));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd2000));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'hFF, 11'd2047));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_WRITE, 8'h00, 11'd0));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_WRITE, 8'hFF, 11'd2047));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_WRITE, 8'h41, 11'd0));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_WRITE, tmtw_pkg::CH_TAB, 11'd0));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_WRITE, tmtw_pkg::CH_NEWLINE, 11'd0));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_WRITE, 8'h5A, 11'd0));
    req_fifo.push_back(make_req(REQ_UNUSED, 8'hFF, 11'd2047));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd0));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd1));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd2));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd80));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd81));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_CLEAR, 8'h0A, 11'd80));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd80));
    req_fifo.push_back(make_req(tmtw_pkg::REQ_READ, 8'h00, 11'd0));
    wait_drained();

    for (int s = 0; s < SEGMENTS; s++) begin
      if (s == 2) begin
        src_gap_pct = 65;
        snk_stall_pct = 38;
      end else if (s == 4) begin
        src_gap_pct = 0;
        snk_stall_pct = 0;
      end
      write_colours(fg_set[s], bg_set[s]);
      for (int k = 0; k < SEG_REQS; k++) req_fifo.push_back(random_req());
      // sender holds off until every result of the segment is back
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * 8000000);
    $display("FAIL");
    $finish;
  end

endmodule
